>>> sv/mwc_pkg.sv
package mwc_pkg;

   // Multiply-with-carry lane multipliers and the seeds in force after reset.
   localparam logic [15:0] MULT_Z = 16'd36969;
   localparam logic [15:0] MULT_W = 16'd18000;
   localparam logic [31:0] RESET_SEED_W = 32'd521288629;
   localparam logic [31:0] RESET_SEED_Z = 32'd362436069;

   // A bounded request gives up after this many draws.
   localparam int DRAW_LIMIT = 32;
   localparam int TRIES_WIDTH = $clog2(DRAW_LIMIT);
   localparam logic [TRIES_WIDTH-1:0] LAST_TRY = TRIES_WIDTH'(DRAW_LIMIT - 1);

   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEED_W = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEED_Z = 2'd1;

   localparam logic [3:0] OP_WORD32    = 4'd0;
   localparam logic [3:0] OP_WORD64    = 4'd1;
   localparam logic [3:0] OP_WORD16    = 4'd2;
   localparam logic [3:0] OP_WORD8     = 4'd3;
   localparam logic [3:0] OP_BIT       = 4'd4;
   localparam logic [3:0] OP_BELOW8    = 4'd5;
   localparam logic [3:0] OP_BELOW16   = 4'd6;
   localparam logic [3:0] OP_BELOW32   = 4'd7;
   localparam logic [3:0] OP_BELOW64   = 4'd8;
   localparam logic [3:0] OP_LOAD_SEED = 4'd9;
   localparam logic [3:0] OP_READ_SEED = 4'd10;

   // Source of one draw.
   typedef enum logic [1:0] {
      KIND_WORD,
      KIND_HALF,
      KIND_BYTE,
      KIND_BIT
   } kind_type;

   // Width to which a bound is truncated.
   typedef enum logic [1:0] {
      WIDTH_8,
      WIDTH_16,
      WIDTH_32,
      WIDTH_64
   } width_type;

   // What goes into the result register.
   typedef enum logic [1:0] {
      RES_ZERO,
      RES_CAND,
      RES_DIFF,
      RES_SEED
   } res_type;

   typedef struct packed {
      logic      accept;
      logic      load_seed;
      logic      setup;
      logic      bounded;
      width_type width;
      logic      draw_hi;
      logic      draw_lo;
      kind_type  kind;
      logic      keep_hi;
      logic      out_load;
      res_type   res_sel;
   } cmd_type;

   typedef struct packed {
      logic low_limit;
      logic lt;
   } status_type;

endpackage

>>> sv/mwc_random_generator.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_operation[3:0], req_bound[63:0]
// rsp       out        rsp_valid / rsp_stall  rsp_value[63:0]
// csr       in         csr_valid / csr_ready  csr_index[1:0], csr_data[31:0]
//
// One item is worked at a time. After an item is accepted, a plain draw goes through setup and
// the low draw state (a 64-bit word through the high draw state first) to the finish state,
// which loads the result register; read seed, load seed and unused codes go straight to the
// finish state, and a bound under two goes from setup to it. The finish state waits while a
// stalled result is held. The next item is taken only after the result loads. A bounded draw
// repeats its draw states and a compare state, for at most 32 draws.
// Reset is synchronous and active high; it restores the default seeds and clears buffers.
// The result sits in an output register, so a stalled result holds only the next item back.
module mwc_random_generator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [3:0]                           req_operation,
   input  logic [63:0]                          req_bound,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [63:0]                          rsp_value,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mwc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [31:0]                          csr_data
);

   mwc_pkg::cmd_type    cmd;
   mwc_pkg::status_type status;

   // Seed registers take a write in any cycle, so the port never holds off.
   assign csr_ready = 1'b1;

   // The controller sequences setup, draws, the rejection test and the result load.
   mwc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd),
      .status        (status)
   );

   // The datapath holds both lanes, the narrow buffers, the bound and the result.
   mwc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_bound (req_bound),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_value (rsp_value)
   );

endmodule

>>> sv/mwc_dp.sv
module mwc_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mwc_pkg::cmd_type                     cmd,
   output mwc_pkg::status_type                  status,
   input  logic [63:0]                          req_bound,
   input  logic                                 csr_valid,
   input  logic [mwc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [31:0]                          csr_data,
   output logic [63:0]                          rsp_value
);

   logic [31:0] seed_w_ff, seed_z_ff;
   logic [31:0] lane_w_ff, lane_w_in, lane_z_ff, lane_z_in;
   logic        half_left_ff, half_left_in;
   logic [31:0] half_buf_ff, half_buf_in;
   logic [1:0]  byte_left_ff, byte_left_in;
   logic [31:0] byte_buf_ff, byte_buf_in;
   logic [4:0]  bit_left_ff, bit_left_in;
   logic [31:0] bit_buf_ff, bit_buf_in;
   logic [63:0] bound_ff, limit_ff, limit_in, mask_ff, mask_in;
   logic [63:0] cand_ff, cand_in, value_ff, value_in;

   logic [31:0] z_next, w_next, word;
   logic [31:0] draw_val;
   logic        need_word;
   logic        draw_any;
   logic [63:0] masked, diff;

   // Smallest all-ones mask that covers v.
   function automatic logic [63:0] cover_mask(input logic [63:0] v);
      logic [63:0] m;
      m = v;
      m = m | (m >> 1);
      m = m | (m >> 2);
      m = m | (m >> 4);
      m = m | (m >> 8);
      m = m | (m >> 16);
      m = m | (m >> 32);
      return m;
   endfunction

   // One step of both lanes.
   assign z_next = {16'd0, mwc_pkg::MULT_Z} * {16'd0, lane_z_ff[15:0]}
                 + {16'd0, lane_z_ff[31:16]};
   assign w_next = {16'd0, mwc_pkg::MULT_W} * {16'd0, lane_w_ff[15:0]}
                 + {16'd0, lane_w_ff[31:16]};
   assign word   = {z_next[15:0], 16'd0} + w_next;

   assign draw_any = cmd.draw_hi | cmd.draw_lo;

   always_comb begin
      half_left_in = half_left_ff;
      half_buf_in  = half_buf_ff;
      byte_left_in = byte_left_ff;
      byte_buf_in  = byte_buf_ff;
      bit_left_in  = bit_left_ff;
      bit_buf_in   = bit_buf_ff;
      need_word    = 1'b0;
      draw_val     = word;
      case (cmd.kind)
         mwc_pkg::KIND_WORD: begin
            need_word = 1'b1;
         end
         mwc_pkg::KIND_HALF: begin
            if (half_left_ff) begin
               half_left_in = 1'b0;
               half_buf_in  = half_buf_ff >> 16;
               draw_val     = {16'd0, half_buf_ff[31:16]};
            end else begin
               need_word    = 1'b1;
               half_left_in = 1'b1;
               half_buf_in  = word;
               draw_val     = {16'd0, word[15:0]};
            end
         end
         mwc_pkg::KIND_BYTE: begin
            if (byte_left_ff != 2'd0) begin
               byte_left_in = byte_left_ff - 2'd1;
               byte_buf_in  = byte_buf_ff >> 8;
               draw_val     = {24'd0, byte_buf_ff[15:8]};
            end else begin
               need_word    = 1'b1;
               byte_left_in = 2'd3;
               byte_buf_in  = word;
               draw_val     = {24'd0, word[7:0]};
            end
         end
         mwc_pkg::KIND_BIT: begin
            if (bit_left_ff != 5'd0) begin
               bit_left_in = bit_left_ff - 5'd1;
               bit_buf_in  = bit_buf_ff >> 1;
               draw_val    = {31'd0, bit_buf_ff[1]};
            end else begin
               need_word   = 1'b1;
               bit_left_in = 5'd31;
               bit_buf_in  = word;
               draw_val    = {31'd0, word[0]};
            end
         end
         default: begin
            need_word = 1'b1;
         end
      endcase

      lane_w_in = lane_w_ff;
      lane_z_in = lane_z_ff;
      if (cmd.load_seed) begin
         lane_w_in    = seed_w_ff;
         lane_z_in    = seed_z_ff;
         half_left_in = 1'b0;
         half_buf_in  = '0;
         byte_left_in = '0;
         byte_buf_in  = '0;
         bit_left_in  = '0;
         bit_buf_in   = '0;
      end else if (draw_any && need_word) begin
         lane_w_in = w_next;
         lane_z_in = z_next;
      end
   end

   // The bound is truncated to the width of the request, then covered by a mask.
   always_comb begin
      case (cmd.width)
         mwc_pkg::WIDTH_8:  limit_in = {56'd0, bound_ff[7:0]};
         mwc_pkg::WIDTH_16: limit_in = {48'd0, bound_ff[15:0]};
         mwc_pkg::WIDTH_32: limit_in = {32'd0, bound_ff[31:0]};
         default:           limit_in = bound_ff;
      endcase
      mask_in = cmd.bounded ? cover_mask(limit_in) : '1;
   end

   assign status.low_limit = (limit_in[63:1] == 63'd0);

   assign masked    = cand_ff & mask_ff;
   assign diff      = masked - limit_ff;
   assign status.lt = (masked < limit_ff);

   always_comb begin
      cand_in = cand_ff;
      if (cmd.draw_hi) begin
         cand_in = {draw_val, 32'd0};
      end else if (cmd.draw_lo) begin
         cand_in = cmd.keep_hi ? {cand_ff[63:32], draw_val} : {32'd0, draw_val};
      end
      case (cmd.res_sel)
         mwc_pkg::RES_CAND: value_in = masked;
         mwc_pkg::RES_DIFF: value_in = diff;
         mwc_pkg::RES_SEED: value_in = {lane_z_ff, lane_w_ff};
         default:           value_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_w_ff    <= mwc_pkg::RESET_SEED_W;
         seed_z_ff    <= mwc_pkg::RESET_SEED_Z;
         lane_w_ff    <= mwc_pkg::RESET_SEED_W;
         lane_z_ff    <= mwc_pkg::RESET_SEED_Z;
         half_left_ff <= 1'b0;
         half_buf_ff  <= '0;
         byte_left_ff <= '0;
         byte_buf_ff  <= '0;
         bit_left_ff  <= '0;
         bit_buf_ff   <= '0;
      end else begin
         if (csr_valid && csr_index == mwc_pkg::CSR_SEED_W) begin
            seed_w_ff <= csr_data;
         end
         if (csr_valid && csr_index == mwc_pkg::CSR_SEED_Z) begin
            seed_z_ff <= csr_data;
         end
         lane_w_ff <= lane_w_in;
         lane_z_ff <= lane_z_in;
         if (draw_any || cmd.load_seed) begin
            half_left_ff <= half_left_in;
            half_buf_ff  <= half_buf_in;
            byte_left_ff <= byte_left_in;
            byte_buf_ff  <= byte_buf_in;
            bit_left_ff  <= bit_left_in;
            bit_buf_ff   <= bit_buf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         bound_ff <= req_bound;
      end
      if (cmd.setup) begin
         limit_ff <= limit_in;
         mask_ff  <= mask_in;
      end
      cand_ff <= cand_in;
      if (cmd.out_load) begin
         value_ff <= value_in;
      end
   end

   assign rsp_value = value_ff;

endmodule

>>> sv/mwc_ctrl.sv
module mwc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [3:0]          req_operation,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mwc_pkg::cmd_type    cmd,
   input  mwc_pkg::status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DRAW_HI,
      ST_DRAW_LO,
      ST_TEST,
      ST_FINISH
   } state_type;

   state_type                       state_ff, state_in;
   logic [3:0]                      op_ff, op_in;
   logic [mwc_pkg::TRIES_WIDTH-1:0] tries_ff, tries_in;
   mwc_pkg::res_type                res_sel_ff, res_sel_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            accept, out_free, bounded, wide;

   function automatic mwc_pkg::kind_type kind_of(input logic [3:0] op);
      mwc_pkg::kind_type k;
      case (op)
         mwc_pkg::OP_WORD16, mwc_pkg::OP_BELOW16: k = mwc_pkg::KIND_HALF;
         mwc_pkg::OP_WORD8,  mwc_pkg::OP_BELOW8:  k = mwc_pkg::KIND_BYTE;
         mwc_pkg::OP_BIT:                         k = mwc_pkg::KIND_BIT;
         default:                                 k = mwc_pkg::KIND_WORD;
      endcase
      return k;
   endfunction

   function automatic mwc_pkg::width_type width_of(input logic [3:0] op);
      mwc_pkg::width_type w;
      case (op)
         mwc_pkg::OP_BELOW8:  w = mwc_pkg::WIDTH_8;
         mwc_pkg::OP_BELOW16: w = mwc_pkg::WIDTH_16;
         mwc_pkg::OP_BELOW32: w = mwc_pkg::WIDTH_32;
         default:             w = mwc_pkg::WIDTH_64;
      endcase
      return w;
   endfunction

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign bounded  = (op_ff == mwc_pkg::OP_BELOW8)  || (op_ff == mwc_pkg::OP_BELOW16) ||
                     (op_ff == mwc_pkg::OP_BELOW32) || (op_ff == mwc_pkg::OP_BELOW64);
   assign wide     = (op_ff == mwc_pkg::OP_WORD64) || (op_ff == mwc_pkg::OP_BELOW64);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      tries_in     = tries_ff;
      res_sel_in   = res_sel_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      cmd           = '0;
      cmd.bounded   = bounded;
      cmd.width     = width_of(op_ff);
      cmd.kind      = kind_of(op_ff);
      cmd.keep_hi   = wide;
      cmd.res_sel   = res_sel_ff;
      cmd.accept    = accept;
      cmd.load_seed = accept && (req_operation == mwc_pkg::OP_LOAD_SEED);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in = req_operation;
               if (req_operation == mwc_pkg::OP_READ_SEED) begin
                  res_sel_in = mwc_pkg::RES_SEED;
                  state_in   = ST_FINISH;
               end else if (req_operation > mwc_pkg::OP_BELOW64) begin
                  res_sel_in = mwc_pkg::RES_ZERO;
                  state_in   = ST_FINISH;
               end else begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            tries_in  = '0;
            if (bounded && status.low_limit) begin
               res_sel_in = mwc_pkg::RES_ZERO;
               state_in   = ST_FINISH;
            end else begin
               state_in = wide ? ST_DRAW_HI : ST_DRAW_LO;
            end
         end
         ST_DRAW_HI: begin
            cmd.draw_hi = 1'b1;
            cmd.kind    = mwc_pkg::KIND_WORD;
            state_in    = ST_DRAW_LO;
         end
         ST_DRAW_LO: begin
            cmd.draw_lo = 1'b1;
            if (bounded) begin
               state_in = ST_TEST;
            end else begin
               res_sel_in = mwc_pkg::RES_CAND;
               state_in   = ST_FINISH;
            end
         end
         ST_TEST: begin
            if (status.lt) begin
               res_sel_in = mwc_pkg::RES_CAND;
               state_in   = ST_FINISH;
            end else if (tries_ff == mwc_pkg::LAST_TRY) begin
               res_sel_in = mwc_pkg::RES_DIFF;
               state_in   = ST_FINISH;
            end else begin
               tries_in = tries_ff + 1'b1;
               state_in = wide ? ST_DRAW_HI : ST_DRAW_LO;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= mwc_pkg::OP_WORD32;
         tries_ff     <= '0;
         res_sel_ff   <= mwc_pkg::RES_ZERO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         tries_ff     <= tries_in;
         res_sel_ff   <= res_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside the finish state");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while still held");

   a_draw_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TEST && !status.lt && tries_ff == mwc_pkg::LAST_TRY)
      |=> (state_ff == ST_FINISH && res_sel_ff == mwc_pkg::RES_DIFF))
      else $error("draw limit not honored");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("controller stayed idle after taking an item");
`endif

endmodule

>>> verif/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // The testbench keeps its own copy of the generator constants, so that a
   // wrong value in the package cannot hide behind a shared definition.
   localparam logic [31:0] Z_FACTOR        = 32'd36969;
   localparam logic [31:0] W_FACTOR        = 32'd18000;
   localparam logic [31:0] SEED_W_AT_RESET = 32'd521288629;
   localparam logic [31:0] SEED_Z_AT_RESET = 32'd362436069;
   localparam int          TRY_CAP         = 32;

   // Operation codes that the block must answer with zero and no state change.
   localparam logic [3:0] OP_SPARE_LO = 4'd11;
   localparam logic [3:0] OP_SPARE_HI = 4'd15;

   // Nonzero fixed points of the two lanes. With lane z at its fixed point and
   // lane w at zero every word is 32'hFFFF_0000, which keeps the bounded
   // draws of the stuck rows rejecting until the draw cap steps in.
   localparam logic [31:0] STUCK_Z = 32'h9068_FFFF;
   localparam logic [31:0] STUCK_W = 32'h464F_FFFF;

   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 178;
   localparam int LONG_HOLD    = 250;
   localparam int DRAIN_CYCLES = 128;
   localparam int CYCLE_LIMIT  = 800_000;

   // One row of the directed stimulus. Where the answer is obvious the row
   // carries it; otherwise the predictor supplies it.
   typedef struct packed {
      logic [3:0]  op;
      logic [63:0] bound;
      logic        known;
      logic [63:0] value;
   } stim_row_type;

   // Opening rows, run on the seeds in force after reset.
   localparam stim_row_type BOOT_ROWS [20] = '{
      '{mwc_pkg::OP_READ_SEED, 64'd0, 1'b1, {SEED_Z_AT_RESET, SEED_W_AT_RESET}},
      '{mwc_pkg::OP_WORD32,    ALL_ONES,                1'b0, 64'd0},
      '{mwc_pkg::OP_WORD64,    64'd0,                   1'b0, 64'd0},
      '{mwc_pkg::OP_WORD16,    ALL_ONES,                1'b0, 64'd0},
      '{mwc_pkg::OP_WORD16,    64'd0,                   1'b0, 64'd0},
      '{mwc_pkg::OP_WORD8,     ALL_ONES,                1'b0, 64'd0},
      '{mwc_pkg::OP_WORD8,     64'd0,                   1'b0, 64'd0},
      '{mwc_pkg::OP_BIT,       ALL_ONES,                1'b0, 64'd0},
      '{mwc_pkg::OP_BIT,       64'd0,                   1'b0, 64'd0},
      '{mwc_pkg::OP_BELOW8,    64'd0,                   1'b1, 64'd0},
      '{mwc_pkg::OP_BELOW16,   64'hFFFF_FFFF_FFFF_0001, 1'b1, 64'd0},
      '{mwc_pkg::OP_BELOW32,   64'hFFFF_FFFF_0000_0001, 1'b1, 64'd0},
      '{mwc_pkg::OP_BELOW8,    64'h0000_0000_0000_00FF, 1'b0, 64'd0},
      '{mwc_pkg::OP_BELOW32,   64'h0000_0000_8000_0001, 1'b0, 64'd0},
      '{mwc_pkg::OP_BELOW64,   ALL_ONES,                1'b0, 64'd0},
      '{mwc_pkg::OP_BELOW64,   64'd2,                   1'b0, 64'd0},
      '{OP_SPARE_LO,           ALL_ONES,                1'b1, 64'd0},
      '{OP_SPARE_HI,           ALL_ONES,                1'b1, 64'd0},
      '{mwc_pkg::OP_LOAD_SEED, ALL_ONES,                1'b1, 64'd0},
      '{mwc_pkg::OP_READ_SEED, ALL_ONES, 1'b1, {SEED_Z_AT_RESET, SEED_W_AT_RESET}}
   };

   // Rows run with lane z stuck and lane w at zero, so that both bounded
   // draws below run out of tries and fall back to the difference.
   localparam stim_row_type STUCK_ROWS [4] = '{
      '{mwc_pkg::OP_LOAD_SEED, 64'd0,                   1'b1, 64'd0},
      '{mwc_pkg::OP_BELOW32,   64'h0000_0000_9000_0000, 1'b0, 64'd0},
      '{mwc_pkg::OP_BELOW64,   64'h8000_0000_0000_0001, 1'b0, 64'd0},
      '{mwc_pkg::OP_READ_SEED, 64'd0,                   1'b1, {STUCK_Z, 32'd0}}
   };

   // Every input of the block starts at a known value.
   logic                                clock           = 1'b0;
   logic                                reset           = 1'b1;
   logic                                req_valid       = 1'b0;
   logic                                req_stall;
   logic [3:0]                          req_operation   = mwc_pkg::OP_WORD32;
   logic [63:0]                         req_bound       = 64'd0;
   logic                                rsp_valid;
   logic                                rsp_stall       = 1'b0;
   logic [63:0]                         rsp_value;
   logic                                csr_valid       = 1'b0;
   logic                                csr_ready;
   logic [mwc_pkg::CSR_INDEX_WIDTH-1:0] csr_index       = mwc_pkg::CSR_SEED_W;
   logic [31:0]                         csr_data        = 32'd0;

   // Side information that travels with the item on the request port.
   logic                                req_known       = 1'b0;
   logic [63:0]                         req_known_value = 64'd0;

   // Predicted generator state and the configuration it will load.
   logic [31:0] cfg_seed_w, cfg_seed_z;
   logic [31:0] lane_w, lane_z;
   logic        half_left;
   logic [31:0] half_buf;
   logic [1:0]  byte_left;
   logic [31:0] byte_buf;
   logic [4:0]  bit_left;
   logic [31:0] bit_buf;

   logic [63:0] pending_values [$];

   int unsigned accepted_items = 0;
   int unsigned results_seen   = 0;
   int unsigned mismatches     = 0;
   int unsigned cap_hits       = 0;
   int unsigned seed_settings  = 0;
   int unsigned cycle_count    = 0;
   int unsigned long_holds     = 0;
   bit          calm_tail      = 1'b0;
   bit          long_hold_req  = 1'b0;

   mwc_random_generator dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_bound     (req_bound),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value     (rsp_value),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor of the generator.
   // ------------------------------------------------------------------

   // Puts both lanes at the given values and empties every narrow buffer.
   function automatic void restart_lanes(logic [31:0] w, logic [31:0] z);
      lane_w    = w;
      lane_z    = z;
      half_left = 1'b0;
      half_buf  = 32'd0;
      byte_left = 2'd0;
      byte_buf  = 32'd0;
      bit_left  = 5'd0;
      bit_buf   = 32'd0;
   endfunction

   // One multiply-with-carry step of both lanes, folded into a 32-bit word.
   function automatic logic [31:0] next_word();
      lane_z = Z_FACTOR * {16'd0, lane_z[15:0]} + {16'd0, lane_z[31:16]};
      lane_w = W_FACTOR * {16'd0, lane_w[15:0]} + {16'd0, lane_w[31:16]};
      return {lane_z[15:0], 16'd0} + lane_w;
   endfunction

   // The first word drawn lands in the upper half.
   function automatic logic [63:0] next_pair();
      logic [31:0] upper, lower;
      upper = next_word();
      lower = next_word();
      return {upper, lower};
   endfunction

   function automatic logic [15:0] next_half();
      if (half_left) begin
         half_left = 1'b0;
         half_buf  = half_buf >> 16;
      end else begin
         half_left = 1'b1;
         half_buf  = next_word();
      end
      return half_buf[15:0];
   endfunction

   function automatic logic [7:0] next_byte();
      if (byte_left != 2'd0) begin
         byte_left = byte_left - 2'd1;
         byte_buf  = byte_buf >> 8;
      end else begin
         byte_left = 2'd3;
         byte_buf  = next_word();
      end
      return byte_buf[7:0];
   endfunction

   function automatic logic next_bit();
      if (bit_left != 5'd0) begin
         bit_left = bit_left - 5'd1;
         bit_buf  = bit_buf >> 1;
      end else begin
         bit_left = 5'd31;
         bit_buf  = next_word();
      end
      return bit_buf[0];
   endfunction

   // Smallest all-ones mask that covers the value.
   function automatic logic [63:0] spread_ones(logic [63:0] v);
      for (int s = 1; s < 64; s = s * 2) v = v | (v >> s);
      return v;
   endfunction

   // Unbiased draw below the bound, with the bound cut to the draw width.
   // A bound under two gives zero without touching the lanes. After the last
   // try the candidate minus the bound is returned, which is below the bound.
   function automatic logic [63:0] draw_below(mwc_pkg::width_type width,
                                              logic [63:0] bound);
      logic [63:0] limit, mask, cand;
      case (width)
         mwc_pkg::WIDTH_8:  limit = {56'd0, bound[7:0]};
         mwc_pkg::WIDTH_16: limit = {48'd0, bound[15:0]};
         mwc_pkg::WIDTH_32: limit = {32'd0, bound[31:0]};
         default:           limit = bound;
      endcase
      if (limit < 64'd2) return 64'd0;
      mask = spread_ones(limit);
      cand = 64'd0;
      for (int t = 0; t < TRY_CAP; t++) begin
         case (width)
            mwc_pkg::WIDTH_8:  cand = {56'd0, next_byte()};
            mwc_pkg::WIDTH_16: cand = {48'd0, next_half()};
            mwc_pkg::WIDTH_32: cand = {32'd0, next_word()};
            default:           cand = next_pair();
         endcase
         cand = cand & mask;
         if (cand < limit) return cand;
      end
      cap_hits++;
      return cand - limit;
   endfunction

   // Value the block owes for one item, advancing the predicted state.
   function automatic logic [63:0] draw_for_item(logic [3:0] op, logic [63:0] bound);
      case (op)
         mwc_pkg::OP_WORD32:    return {32'd0, next_word()};
         mwc_pkg::OP_WORD64:    return next_pair();
         mwc_pkg::OP_WORD16:    return {48'd0, next_half()};
         mwc_pkg::OP_WORD8:     return {56'd0, next_byte()};
         mwc_pkg::OP_BIT:       return {63'd0, next_bit()};
         mwc_pkg::OP_BELOW8:    return draw_below(mwc_pkg::WIDTH_8, bound);
         mwc_pkg::OP_BELOW16:   return draw_below(mwc_pkg::WIDTH_16, bound);
         mwc_pkg::OP_BELOW32:   return draw_below(mwc_pkg::WIDTH_32, bound);
         mwc_pkg::OP_BELOW64:   return draw_below(mwc_pkg::WIDTH_64, bound);
         mwc_pkg::OP_LOAD_SEED: begin
            restart_lanes(cfg_seed_w, cfg_seed_z);
            return 64'd0;
         end
         mwc_pkg::OP_READ_SEED: return {lane_z, lane_w};
         default:               return 64'd0;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Checking.
   // ------------------------------------------------------------------

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      $display("mismatch %0d at cycle %0d: %s, got %h, expected %h",
               mismatches, cycle_count, what, got, want);
   endtask

   // All handshakes are sampled here, at the clock edge, from the values
   // that held just before it. Configuration writes go to the predicted
   // seeds, accepted items are predicted at once, and each accepted result
   // is compared with the oldest prediction still waiting.
   always @(posedge clock) begin : watch_ports
      logic [63:0] want;
      if (reset) begin
         cfg_seed_w = SEED_W_AT_RESET;
         cfg_seed_z = SEED_Z_AT_RESET;
         restart_lanes(SEED_W_AT_RESET, SEED_Z_AT_RESET);
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mwc_pkg::CSR_SEED_W: cfg_seed_w = csr_data;
               mwc_pkg::CSR_SEED_Z: cfg_seed_z = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            // The predictor always runs so that its state stays in step;
            // a row with a written answer takes that answer instead.
            want = draw_for_item(req_operation, req_bound);
            if (req_known) want = req_known_value;
            pending_values.push_back(want);
            accepted_items++;
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pending_values.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_value, 64'd0);
            end else begin
               want = pending_values.pop_front();
               if (rsp_value !== want) report_mismatch("value", rsp_value, want);
            end
         end
      end
   end

   // A hung block ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run stopped after %0d cycles with %0d results still owed",
                  cycle_count, pending_values.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Result side: the receiver stalls in random bursts, with clean stretches
   // in between. Once it holds off for a long stretch while the sender keeps
   // offering items, which fills the block and makes it stall its input.
   // In the last phase it never stalls.
   // ------------------------------------------------------------------
   initial begin : drive_rsp_stall
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
            long_holds++;
         end else if (!calm_tail && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side.
   // ------------------------------------------------------------------

   // Offers one item and holds it until it is taken. Valid stays high when
   // the next item follows at once; otherwise a random gap may follow.
   task automatic send_item(input logic [3:0] op, input logic [63:0] bound,
                            input logic known, input logic [63:0] value);
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_bound       <= bound;
      req_known       <= known;
      req_known_value <= value;
      do @(posedge clock); while (req_stall);
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // Waits until every accepted item has had its result. Every item gives
   // exactly one result, so the block is idle from then on. The first edge
   // lets the port watcher account for an item taken at the current edge.
   task automatic wait_idle();
      @(posedge clock);
      while (results_seen != accepted_items) @(posedge clock);
   endtask

   // Writes both seed registers, in random order, with valid held high
   // across the pair.
   task automatic write_seeds(input logic [31:0] w, input logic [31:0] z);
      logic                                w_first;
      logic [mwc_pkg::CSR_INDEX_WIDTH-1:0] idx0, idx1;
      logic [31:0]                         data0, data1;
      w_first = 1'($urandom_range(0, 1));
      idx0  = w_first ? mwc_pkg::CSR_SEED_W : mwc_pkg::CSR_SEED_Z;
      data0 = w_first ? w : z;
      idx1  = w_first ? mwc_pkg::CSR_SEED_Z : mwc_pkg::CSR_SEED_W;
      data1 = w_first ? z : w;
      csr_valid <= 1'b1;
      csr_index <= idx0;
      csr_data  <= data0;
      do @(posedge clock); while (!csr_ready);
      csr_index <= idx1;
      csr_data  <= data1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      seed_settings++;
   endtask

   // Bounds spread over every size, so that each draw width sees tight and
   // loose masks, plus values near powers of two and bounds under two.
   function automatic logic [63:0] random_bound();
      logic [63:0] full;
      full = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0:       return 64'($urandom_range(0, 3));
         1:       return full;
         2:       return (64'd1 << $urandom_range(1, 63)) + 64'($urandom_range(0, 2)) - 64'd1;
         default: return full >> $urandom_range(0, 63);
      endcase
   endfunction

   // Mostly draws of every kind, with seed loads, seed reads and unused
   // codes mixed in.
   function automatic logic [3:0] random_operation();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) return 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      if (pick < 9) return mwc_pkg::OP_LOAD_SEED;
      if (pick < 13) return mwc_pkg::OP_READ_SEED;
      return 4'($urandom_range(mwc_pkg::OP_WORD32, mwc_pkg::OP_BELOW64));
   endfunction

   // Main sequence: reset, the directed rows on the reset seeds, the rows
   // on stuck lanes, then random phases, each on its own seed setting.
   initial begin : run_test
      logic [31:0] phase_w, phase_z;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (BOOT_ROWS[i])
         send_item(BOOT_ROWS[i].op, BOOT_ROWS[i].bound, BOOT_ROWS[i].known,
                   BOOT_ROWS[i].value);
      req_valid <= 1'b0;
      wait_idle();

      write_seeds(32'd0, STUCK_Z);
      foreach (STUCK_ROWS[i])
         send_item(STUCK_ROWS[i].op, STUCK_ROWS[i].bound, STUCK_ROWS[i].known,
                   STUCK_ROWS[i].value);
      req_valid <= 1'b0;
      wait_idle();

      for (int phase = 0; phase < PHASES; phase++) begin
         // Seed settings include all zeros, all ones, the stuck points, zero w
         // with all-ones z and the reset values; the remaining phases get random seeds.
         phase_w = $urandom;
         phase_z = $urandom;
         case (phase)
            0: begin phase_w = 32'd0;        phase_z = 32'd0;        end
            1: begin phase_w = 32'hFFFF_FFFF; phase_z = 32'hFFFF_FFFF; end
            3: begin phase_w = STUCK_W;      phase_z = STUCK_Z;      end
            5: begin phase_w = 32'd0;        phase_z = 32'hFFFF_FFFF; end
            7: begin phase_w = SEED_W_AT_RESET; phase_z = SEED_Z_AT_RESET; end
            default: ;
         endcase
         if (phase == PHASES - 1) calm_tail = 1'b1;
         write_seeds(phase_w, phase_z);

         // A phase opens with a seed load so that the new seeds take effect.
         send_item(mwc_pkg::OP_LOAD_SEED, random_bound(), 1'b0, 64'd0);
         if (phase == 2) long_hold_req = 1'b1;
         repeat (PHASE_ITEMS)
            send_item(random_operation(), random_bound(), 1'b0, 64'd0);
         req_valid <= 1'b0;
         wait_idle();
      end

      // Anything the block produces from here on is a stray result.
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (pending_values.size() != 0)
         report_mismatch("result never arrived", 64'd0, pending_values.pop_front());

      $display("Checked %0d results over %0d seed settings; %0d bounded draws hit the try cap.",
               results_seen, seed_settings, cap_hits);
      $display("Receiver held off %0d time(s) for %0d cycles; the last phase ran without idling.",
               long_holds, LONG_HOLD);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> files.f
sv/mwc_pkg.sv
sv/mwc_dp.sv
sv/mwc_ctrl.sv
sv/mwc_random_generator.sv
verif/tb_top.sv
